// ===== design/feedback_arc_set_ordering_top_assert.svh =====
// Assertion macros shared by the feedback arc set ordering RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef FEEDBACK_ARC_SET_ORDERING_TOP_ASSERT_SVH
`define FEEDBACK_ARC_SET_ORDERING_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define FASO_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define FASO_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define FASO_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define FASO_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== design/faso_pkg.sv =====
// Shared constants, command codes and status struct for the ordering block.
// Used by the controller, the datapath and the top level.
`default_nettype none
package faso_pkg;

   localparam int MAX_NODES = 64;
   localparam int IDX_W     = $clog2(MAX_NODES);
   localparam int CNT_W     = IDX_W + 1;
   localparam int ADDR_W    = 2 * IDX_W;
   localparam int ENTRY_W   = 24;
   localparam int WT_W      = 10;
   localparam int SUM_W     = 40;
   localparam int GAIN_W    = 32;
   localparam int ROUND_W   = 8;
   localparam int MODE_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;

   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ROUNDS = 2'd1;

   // Datapath micro-operations issued by the controller.
   typedef enum logic [5:0] {
      OP_NONE, OP_CLR, OP_LOAD, OP_ADD_RD, OP_ADD_WR, OP_RUN_INIT,
      OP_TOT_RD, OP_TOT_ACC, OP_ID_INIT, OP_ID_WR, OP_BW_INIT, OP_BW_I0,
      OP_BW_I1, OP_BW_J0, OP_BW_J1, OP_BW_J2, OP_BW_DONE, OP_P_I0, OP_P_I1,
      OP_P_J0, OP_P_J1, OP_P_J2, OP_P_J3, OP_P_MV, OP_SH_RD, OP_SH_WR,
      OP_SH_FIN, OP_P_NEXT, OP_REV_INIT, OP_REV_R0, OP_REV_R1, OP_REV_W0,
      OP_REV_W1, OP_EM_INIT, OP_EM_RD, OP_EM_LD
   } op_type;

   // Datapath conditions that steer the controller.
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic clr_last;
      logic tot_last;
      logic i_last;
      logic j_last;
      logic j_zero;
      logic moved;
      logic k_at_best;
      logic brk;
      logic cont;
      logic a_lt_b;
      logic rsp_busy;
   } status_type;

endpackage
`default_nettype wire

// ===== design/feedback_arc_set_ordering_top.sv =====
// An add reads and writes back one cost entry, a clear sweeps the whole cost matrix, and a run
// forms the total weight and the identity order, then per round the backward sum over each pair,
// the gain steps and the shifted entries; the result beats follow while the receiver is ready.
// Throughput: one item at a time; the next item is accepted once the previous one is done,
// and an item may enter while the last beat waits. Configuration writes are taken every cycle.
// Reset: synchronous, active high; a pass then clears all 4096 cost entries, no input.
`default_nettype none
module feedback_arc_set_ordering_top (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  wire [faso_pkg::MODE_W-1:0]     req_mode,
   input  wire [faso_pkg::IDX_W-1:0]      req_from_node,
   input  wire [faso_pkg::IDX_W-1:0]      req_to_node,
   input  wire [faso_pkg::WT_W-1:0]       req_weight,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic [faso_pkg::IDX_W-1:0]     rsp_position,
   output logic [faso_pkg::IDX_W-1:0]     rsp_node,
   output logic [faso_pkg::SUM_W-1:0]     rsp_forward_weight,
   output logic                           rsp_last,
   input  wire                            csr_valid,
   output logic                           csr_ready,
   input  wire [faso_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [faso_pkg::CSR_DAT_W-1:0]  csr_data
);
   import faso_pkg::*;

   op_type     cmd;
   status_type status;

   assign csr_ready = 1'b1;

   // Sequencer.
   faso_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .status(status), .cmd(cmd)
   );

   // Memories, arithmetic and the result register.
   faso_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_mode(req_mode), .req_from_node(req_from_node), .req_to_node(req_to_node),
      .req_weight(req_weight), .csr_valid(csr_valid), .csr_index(csr_index),
      .csr_data(csr_data), .rsp_ready(rsp_ready), .rsp_valid(rsp_valid),
      .rsp_position(rsp_position), .rsp_node(rsp_node),
      .rsp_forward_weight(rsp_forward_weight), .rsp_last(rsp_last)
   );

endmodule
`default_nettype wire

// ===== design/faso_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module faso_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire                     clock,
   input  wire                     we,
   input  wire [$clog2(DEPTH)-1:0] waddr,
   input  wire [WIDTH-1:0]         wdata,
   input  wire [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]        rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

// ===== design/faso_dp.sv =====
// Datapath: cost and order memories, counters, weights and result register.
// Depends on faso_pkg, faso_ram and the assertion macro header.
`default_nettype none
`include "feedback_arc_set_ordering_top_assert.svh"
module faso_dp (
   input  wire                                clock,
   input  wire                                reset,
   input  faso_pkg::op_type                   cmd,
   output faso_pkg::status_type               status,
   input  wire [faso_pkg::MODE_W-1:0]         req_mode,
   input  wire [faso_pkg::IDX_W-1:0]          req_from_node,
   input  wire [faso_pkg::IDX_W-1:0]          req_to_node,
   input  wire [faso_pkg::WT_W-1:0]           req_weight,
   input  wire                                csr_valid,
   input  wire [faso_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [faso_pkg::CSR_DAT_W-1:0]      csr_data,
   input  wire                                rsp_ready,
   output logic                               rsp_valid,
   output logic [faso_pkg::IDX_W-1:0]         rsp_position,
   output logic [faso_pkg::IDX_W-1:0]         rsp_node,
   output logic [faso_pkg::SUM_W-1:0]         rsp_forward_weight,
   output logic                               rsp_last
);
   import faso_pkg::*;

   logic [CNT_W-1:0]     node_count_ff, node_count_in;
   logic [ROUND_W-1:0]   max_rounds_ff, max_rounds_in;
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [IDX_W-1:0]     from_ff, from_in, to_ff, to_in;
   logic [WT_W-1:0]      weight_ff, weight_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   logic [CNT_W-1:0]     n_ff, n_in, i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [CNT_W-1:0]     best_ff, best_in;
   logic [IDX_W-1:0]     mover_ff, mover_in, other_ff, other_in;
   logic [ENTRY_W-1:0]   tmp_ff, tmp_in;
   logic signed [GAIN_W-1:0] gain_ff, gain_in, best_gain_ff, best_gain_in, gain_sum;
   logic [SUM_W-1:0]     acc_ff, acc_in, bw_ff, bw_in, start_ff, start_in;
   logic [SUM_W-1:0]     before_ff, before_in, tot_ff, tot_in;
   logic [ROUND_W-1:0]   rounds_ff, rounds_in;
   logic                 rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [IDX_W-1:0]     rsp_pos_ff, rsp_pos_in, rsp_node_ff, rsp_node_in;
   logic [SUM_W-1:0]     rsp_fwd_ff, rsp_fwd_in;

   logic                 c_we, o_we;
   logic [ADDR_W-1:0]    c_waddr, c_raddr;
   logic [ENTRY_W-1:0]   c_wdata, c_rdata;
   logic [IDX_W-1:0]     o_waddr, o_raddr, o_wdata, o_rdata;

   logic [CNT_W-1:0]     n_m1, j_m1, k_m1;
   logic [ENTRY_W:0]     add_sum;
   logic [CNT_W-1:0]     n_clamp;

   faso_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_NODES * MAX_NODES)) u_cost (
      .clock(clock), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
      .raddr(c_raddr), .rdata(c_rdata)
   );

   faso_ram #(.WIDTH(IDX_W), .DEPTH(MAX_NODES)) u_order (
      .clock(clock), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
      .raddr(o_raddr), .rdata(o_rdata)
   );

   assign n_m1 = n_ff - CNT_W'(1);
   assign j_m1 = j_ff - CNT_W'(1);
   assign k_m1 = k_ff - CNT_W'(1);
   assign add_sum = {1'b0, c_rdata} + (ENTRY_W + 1)'(weight_ff);
   assign gain_sum = gain_ff + $signed({{(GAIN_W - ENTRY_W){1'b0}}, tmp_ff})
                             - $signed({{(GAIN_W - ENTRY_W){1'b0}}, c_rdata});

   // Node count limited to the supported range.
   always_comb begin
      if (node_count_ff < CNT_W'(2)) begin
         n_clamp = CNT_W'(2);
      end else if (node_count_ff > CNT_W'(MAX_NODES)) begin
         n_clamp = CNT_W'(MAX_NODES);
      end else begin
         n_clamp = node_count_ff;
      end
   end

   // Conditions reported to the controller.
   always_comb begin
      status.mode      = mode_ff;
      status.clr_last  = (clr_ff == {ADDR_W{1'b1}});
      status.tot_last  = (i_ff == n_m1) && (j_ff == n_m1);
      status.i_last    = (i_ff == n_m1);
      status.j_last    = (j_ff == n_m1);
      status.j_zero    = (j_ff == '0);
      status.moved     = (best_ff != i_ff);
      status.k_at_best = (k_m1 == best_ff);
      status.brk       = (rounds_ff != '0) && (bw_ff == before_ff);
      status.cont      = (start_ff != bw_ff) && (rounds_ff < max_rounds_ff);
      status.a_lt_b    = (i_ff < j_ff);
      status.rsp_busy  = rsp_valid_ff;
   end

   // Micro-operation decode.
   always_comb begin
      node_count_in = node_count_ff;
      max_rounds_in = max_rounds_ff;
      mode_in = mode_ff;
      from_in = from_ff;
      to_in = to_ff;
      weight_in = weight_ff;
      clr_in = clr_ff;
      n_in = n_ff;
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      best_in = best_ff;
      mover_in = mover_ff;
      other_in = other_ff;
      tmp_in = tmp_ff;
      gain_in = gain_ff;
      best_gain_in = best_gain_ff;
      acc_in = acc_ff;
      bw_in = bw_ff;
      start_in = start_ff;
      before_in = before_ff;
      tot_in = tot_ff;
      rounds_in = rounds_ff;
      rsp_pos_in = rsp_pos_ff;
      rsp_node_in = rsp_node_ff;
      rsp_fwd_in = rsp_fwd_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      c_we = 1'b0;
      c_waddr = {from_ff, to_ff};
      c_wdata = '0;
      c_raddr = {from_ff, to_ff};
      o_we = 1'b0;
      o_waddr = i_ff[IDX_W-1:0];
      o_wdata = i_ff[IDX_W-1:0];
      o_raddr = i_ff[IDX_W-1:0];

      if (csr_valid) begin
         case (csr_index)
            CSR_NODE_COUNT: node_count_in = csr_data[CNT_W-1:0];
            CSR_MAX_ROUNDS: max_rounds_in = csr_data[ROUND_W-1:0];
            default: ;
         endcase
      end

      case (cmd)
         OP_CLR: begin
            c_we = 1'b1;
            c_waddr = clr_ff;
            clr_in = clr_ff + ADDR_W'(1);
         end
         OP_LOAD: begin
            mode_in = req_mode;
            from_in = req_from_node;
            to_in = req_to_node;
            weight_in = req_weight;
         end
         OP_ADD_WR: begin
            c_we = 1'b1;
            c_wdata = add_sum[ENTRY_W] ? {ENTRY_W{1'b1}} : add_sum[ENTRY_W-1:0];
         end
         OP_RUN_INIT: begin
            n_in = n_clamp;
            i_in = '0;
            j_in = '0;
            acc_in = '0;
            rounds_in = '0;
         end
         OP_TOT_RD: c_raddr = {i_ff[IDX_W-1:0], j_ff[IDX_W-1:0]};
         OP_TOT_ACC: begin
            acc_in = acc_ff + SUM_W'(c_rdata);
            if (j_ff == n_m1) begin
               j_in = '0;
               i_in = i_ff + CNT_W'(1);
            end else begin
               j_in = j_ff + CNT_W'(1);
            end
         end
         OP_ID_INIT: begin
            tot_in = acc_ff;
            i_in = '0;
         end
         OP_ID_WR: begin
            o_we = 1'b1;
            i_in = i_ff + CNT_W'(1);
         end
         OP_BW_INIT: begin
            acc_in = '0;
            i_in = '0;
         end
         OP_BW_I0: j_in = i_ff + CNT_W'(1);
         OP_BW_I1: mover_in = o_rdata;
         OP_BW_J0: o_raddr = j_ff[IDX_W-1:0];
         OP_BW_J1: c_raddr = {o_rdata, mover_ff};
         OP_BW_J2: begin
            acc_in = acc_ff + SUM_W'(c_rdata);
            if (j_ff == n_m1) begin
               i_in = i_ff + CNT_W'(1);
            end else begin
               j_in = j_ff + CNT_W'(1);
            end
         end
         OP_BW_DONE: begin
            bw_in = acc_ff;
            start_in = acc_ff;
            i_in = '0;
         end
         OP_P_I1: begin
            mover_in = o_rdata;
            best_in = i_ff;
            gain_in = '0;
            best_gain_in = '0;
            j_in = i_ff;
         end
         OP_P_J0: begin
            o_raddr = j_m1[IDX_W-1:0];
            if (j_ff != '0) begin
               j_in = j_m1;
            end
         end
         OP_P_J1: begin
            other_in = o_rdata;
            c_raddr = {o_rdata, mover_ff};
         end
         OP_P_J2: begin
            tmp_in = c_rdata;
            c_raddr = {mover_ff, other_ff};
         end
         OP_P_J3: begin
            gain_in = gain_sum;
            if (gain_sum < best_gain_ff) begin
               best_gain_in = gain_sum;
               best_in = j_ff;
            end
         end
         OP_P_MV: k_in = i_ff;
         OP_SH_RD: o_raddr = k_m1[IDX_W-1:0];
         OP_SH_WR: begin
            o_we = 1'b1;
            o_waddr = k_ff[IDX_W-1:0];
            o_wdata = o_rdata;
            k_in = k_m1;
         end
         OP_SH_FIN: begin
            o_we = 1'b1;
            o_waddr = best_ff[IDX_W-1:0];
            o_wdata = mover_ff;
            bw_in = bw_ff + {{(SUM_W - GAIN_W){best_gain_ff[GAIN_W-1]}}, best_gain_ff};
         end
         OP_P_NEXT: i_in = i_ff + CNT_W'(1);
         OP_REV_INIT: begin
            rounds_in = rounds_ff + ROUND_W'(1);
            before_in = bw_ff;
            i_in = '0;
            j_in = n_m1;
         end
         OP_REV_R1: begin
            other_in = o_rdata;
            o_raddr = j_ff[IDX_W-1:0];
         end
         OP_REV_W0: begin
            o_we = 1'b1;
            o_wdata = o_rdata;
         end
         OP_REV_W1: begin
            o_we = 1'b1;
            o_waddr = j_ff[IDX_W-1:0];
            o_wdata = other_ff;
            i_in = i_ff + CNT_W'(1);
            j_in = j_m1;
         end
         OP_EM_INIT: i_in = '0;
         OP_EM_LD: begin
            rsp_valid_in = 1'b1;
            rsp_pos_in = i_ff[IDX_W-1:0];
            rsp_node_in = o_rdata;
            rsp_fwd_in = tot_ff - bw_ff;
            rsp_last_in = (i_ff == n_m1);
            i_in = i_ff + CNT_W'(1);
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= CNT_W'(32);
         max_rounds_ff <= ROUND_W'(64);
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         max_rounds_ff <= max_rounds_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      from_ff <= from_in;
      to_ff <= to_in;
      weight_ff <= weight_in;
      n_ff <= n_in;
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      best_ff <= best_in;
      mover_ff <= mover_in;
      other_ff <= other_in;
      tmp_ff <= tmp_in;
      gain_ff <= gain_in;
      best_gain_ff <= best_gain_in;
      acc_ff <= acc_in;
      bw_ff <= bw_in;
      start_ff <= start_in;
      before_ff <= before_in;
      tot_ff <= tot_in;
      rounds_ff <= rounds_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_node_ff <= rsp_node_in;
      rsp_fwd_ff <= rsp_fwd_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_node = rsp_node_ff;
   assign rsp_forward_weight = rsp_fwd_ff;
   assign rsp_last = rsp_last_ff;

   // A result is loaded only into an empty output register.
   `FASO_ASSERT_IMP(a_emit_free, clock, reset, cmd == OP_EM_LD, !rsp_valid_ff)
   // Shifting always moves entries above the insertion point.
   `FASO_ASSERT_IMP(a_shift_above, clock, reset, cmd == OP_SH_WR, k_ff > best_ff)
   // A node is only reinserted for a strictly negative gain.
   `FASO_ASSERT_IMP(a_gain_neg, clock, reset, cmd == OP_SH_FIN, best_gain_ff < 0)

endmodule
`default_nettype wire

// ===== design/faso_ctrl.sv =====
// Controller: sequences clears, edge adds, ordering runs and result beats.
// Depends on faso_pkg.
`default_nettype none
module faso_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  faso_pkg::status_type status,
   output faso_pkg::op_type     cmd
);
   import faso_pkg::*;

   typedef enum logic [36:0] {
      ST_CLR     = 37'd1 << 0,  ST_IDLE    = 37'd1 << 1,  ST_DEC     = 37'd1 << 2,
      ST_ADD_RD  = 37'd1 << 3,  ST_ADD_WR  = 37'd1 << 4,  ST_RUN     = 37'd1 << 5,
      ST_TOT_RD  = 37'd1 << 6,  ST_TOT_ACC = 37'd1 << 7,  ST_ID_INIT = 37'd1 << 8,
      ST_ID_WR   = 37'd1 << 9,  ST_BW_INIT = 37'd1 << 10, ST_BW_I0   = 37'd1 << 11,
      ST_BW_I1   = 37'd1 << 12, ST_BW_J0   = 37'd1 << 13, ST_BW_J1   = 37'd1 << 14,
      ST_BW_J2   = 37'd1 << 15, ST_BW_DONE = 37'd1 << 16, ST_P_I0    = 37'd1 << 17,
      ST_P_I1    = 37'd1 << 18, ST_P_J0    = 37'd1 << 19, ST_P_J1    = 37'd1 << 20,
      ST_P_J2    = 37'd1 << 21, ST_P_J3    = 37'd1 << 22, ST_P_MV    = 37'd1 << 23,
      ST_SH_RD   = 37'd1 << 24, ST_SH_WR   = 37'd1 << 25, ST_SH_FIN  = 37'd1 << 26,
      ST_P_NEXT  = 37'd1 << 27, ST_R_CHK   = 37'd1 << 28, ST_REV_INIT = 37'd1 << 29,
      ST_REV_R0  = 37'd1 << 30, ST_REV_R1  = 37'd1 << 31, ST_REV_W0  = 37'd1 << 32,
      ST_REV_W1  = 37'd1 << 33, ST_EM_INIT = 37'd1 << 34, ST_EM_RD   = 37'd1 << 35,
      ST_EM_LD   = 37'd1 << 36
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Next state and the command issued in each state.
   always_comb begin
      state_in = state_ff;
      cmd = OP_NONE;
      case (state_ff)
         ST_CLR: begin
            cmd = OP_CLR;
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd = OP_LOAD;
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            case (status.mode)
               MODE_ADD:   state_in = ST_ADD_RD;
               MODE_RUN:   state_in = ST_RUN;
               MODE_CLEAR: state_in = ST_CLR;
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_ADD_RD: begin
            cmd = OP_ADD_RD;
            state_in = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            cmd = OP_ADD_WR;
            state_in = ST_IDLE;
         end
         ST_RUN: begin
            cmd = OP_RUN_INIT;
            state_in = ST_TOT_RD;
         end
         ST_TOT_RD: begin
            cmd = OP_TOT_RD;
            state_in = ST_TOT_ACC;
         end
         ST_TOT_ACC: begin
            cmd = OP_TOT_ACC;
            state_in = status.tot_last ? ST_ID_INIT : ST_TOT_RD;
         end
         ST_ID_INIT: begin
            cmd = OP_ID_INIT;
            state_in = ST_ID_WR;
         end
         ST_ID_WR: begin
            cmd = OP_ID_WR;
            if (status.i_last) state_in = ST_BW_INIT;
         end
         ST_BW_INIT: begin
            cmd = OP_BW_INIT;
            state_in = ST_BW_I0;
         end
         ST_BW_I0: begin
            cmd = OP_BW_I0;
            state_in = status.i_last ? ST_BW_DONE : ST_BW_I1;
         end
         ST_BW_I1: begin
            cmd = OP_BW_I1;
            state_in = ST_BW_J0;
         end
         ST_BW_J0: begin
            cmd = OP_BW_J0;
            state_in = ST_BW_J1;
         end
         ST_BW_J1: begin
            cmd = OP_BW_J1;
            state_in = ST_BW_J2;
         end
         ST_BW_J2: begin
            cmd = OP_BW_J2;
            state_in = status.j_last ? ST_BW_I0 : ST_BW_J0;
         end
         ST_BW_DONE: begin
            cmd = OP_BW_DONE;
            state_in = ST_P_I0;
         end
         ST_P_I0: begin
            cmd = OP_P_I0;
            state_in = ST_P_I1;
         end
         ST_P_I1: begin
            cmd = OP_P_I1;
            state_in = ST_P_J0;
         end
         ST_P_J0: begin
            cmd = OP_P_J0;
            state_in = status.j_zero ? ST_P_MV : ST_P_J1;
         end
         ST_P_J1: begin
            cmd = OP_P_J1;
            state_in = ST_P_J2;
         end
         ST_P_J2: begin
            cmd = OP_P_J2;
            state_in = ST_P_J3;
         end
         ST_P_J3: begin
            cmd = OP_P_J3;
            state_in = ST_P_J0;
         end
         ST_P_MV: begin
            cmd = OP_P_MV;
            state_in = status.moved ? ST_SH_RD : ST_P_NEXT;
         end
         ST_SH_RD: begin
            cmd = OP_SH_RD;
            state_in = ST_SH_WR;
         end
         ST_SH_WR: begin
            cmd = OP_SH_WR;
            state_in = status.k_at_best ? ST_SH_FIN : ST_SH_RD;
         end
         ST_SH_FIN: begin
            cmd = OP_SH_FIN;
            state_in = ST_P_NEXT;
         end
         ST_P_NEXT: begin
            cmd = OP_P_NEXT;
            state_in = status.i_last ? ST_R_CHK : ST_P_I0;
         end
         ST_R_CHK: begin
            if (status.brk) begin
               state_in = ST_EM_INIT;
            end else if (status.cont) begin
               state_in = ST_REV_INIT;
            end else begin
               state_in = ST_EM_INIT;
            end
         end
         ST_REV_INIT: begin
            cmd = OP_REV_INIT;
            state_in = ST_REV_R0;
         end
         ST_REV_R0: begin
            cmd = OP_REV_R0;
            state_in = status.a_lt_b ? ST_REV_R1 : ST_BW_INIT;
         end
         ST_REV_R1: begin
            cmd = OP_REV_R1;
            state_in = ST_REV_W0;
         end
         ST_REV_W0: begin
            cmd = OP_REV_W0;
            state_in = ST_REV_W1;
         end
         ST_REV_W1: begin
            cmd = OP_REV_W1;
            state_in = ST_REV_R0;
         end
         ST_EM_INIT: begin
            cmd = OP_EM_INIT;
            state_in = ST_EM_RD;
         end
         ST_EM_RD: begin
            cmd = OP_EM_RD;
            if (!status.rsp_busy) state_in = ST_EM_LD;
         end
         ST_EM_LD: begin
            cmd = OP_EM_LD;
            state_in = status.i_last ? ST_IDLE : ST_EM_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register; reset starts the matrix clearing sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire
